@@ rtl/core/mt_pkg.sv @@
// Shared types and constants for the MT19937 generator.
// No dependencies.
`default_nettype none
package mt_pkg;
	localparam int STATE_WORDS_DEF  = 624;
	localparam int TWIST_OFFSET_DEF = 397;
	localparam logic [31:0] TWIST_XOR  = 32'h9908b0df;
	localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C   = 32'hefc60000;
	localparam logic [31:0] INIT_MULT  = 32'd1812433253;
	localparam logic [31:0] MIX1_MULT  = 32'd1664525;
	localparam logic [31:0] MIX2_MULT  = 32'd1566083941;
	localparam logic [31:0] INIT_SEED  = 32'd19650218;
	localparam logic [31:0] HIGH_BIT   = 32'h80000000;

	typedef enum logic [1:0] {
		OP_RESEED = 2'd0,
		OP_BITS   = 2'd1,
		OP_BOUND  = 2'd2,
		OP_FRAC   = 2'd3
	} op_t;

	// datapath commands
	typedef enum logic [3:0] {
		DP_NOP,
		DP_INIT_START,  // write word 0 = INIT_SEED, prev = it, idx = 1
		DP_INIT_STEP,   // word[idx] = f(prev), idx++
		DP_MIX_START,   // idx = 1, j = 0, read word 1
		DP_MIX_STEP,    // mix pass 1 step
		DP_MIX2_STEP,   // mix pass 2 step
		DP_FINAL,       // word 0 = HIGH_BIT
		DP_TW_START,    // begin twist
		DP_TW_STEP,
		DP_DRAW         // fetch and temper word at pos
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t    cmd;
		logic       key_two;
	} mt_ctl_t;

	typedef struct packed {
		logic        busy;
		logic        word_ok;
		logic [31:0] word;
		logic        need_twist;
	} mt_sts_t;

	function automatic logic [31:0] temper(input logic [31:0] y0);
		logic [31:0] y;
		y = y0 ^ (y0 >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/mt19937_random_generator.sv @@
// MT19937 random generator top level: controller plus datapath.
// Depends on mt_pkg, mt_ctrl, mt_datapath.
//
// Usage: one input transaction (op, seed, bits, bound) yields one output
// transaction (value, error). Both channels use valid/stall handshakes.
// A reseed walks the 624-word store three times (init, two mix passes).
// A draw reads and tempers one word; when the store is exhausted a twist
// of the whole store runs first. A 53-bit draw takes two words; a bounded
// draw repeats until a word falls below the bound. Refused draws answer
// in the cycle after they are accepted. One transaction is in flight at
// a time; input stalls while a result waits. After reset the block is
// unseeded and every draw is refused with error set until the first
// reseed.
`default_nettype none
module mt19937_random_generator import mt_pkg::*; #(
	parameter int STATE_WORDS  = STATE_WORDS_DEF,
	parameter int TWIST_OFFSET = TWIST_OFFSET_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic signed [63:0] seed,
	input  wire logic [5:0]  bits,
	input  wire logic [30:0] bound,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [52:0]      value,
	output logic             error
);
	mt_ctl_t     ctl;
	mt_sts_t     sts;
	logic [31:0] key0, key1;

	mt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .op, .seed(seed), .bits, .bound,
		.out_valid, .out_stall, .value, .error, .ctl, .key0, .key1, .sts
	);

	mt_datapath #(.STATE_WORDS(STATE_WORDS), .TWIST_OFFSET(TWIST_OFFSET)) u_dp (
		.clk, .arst_n, .ctl, .key0, .key1, .sts
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> value == '0) else $error("error with nonzero value");
	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
endmodule
`default_nettype wire

@@ rtl/core/mt_datapath.sv @@
// Datapath: word store memory, seeding/mixing/twist sequences, tempering.
// Depends on mt_pkg.
`default_nettype none
module mt_datapath import mt_pkg::*; #(
	parameter int STATE_WORDS  = STATE_WORDS_DEF,
	parameter int TWIST_OFFSET = TWIST_OFFSET_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mt_ctl_t     ctl,
	input  wire logic [31:0] key0,
	input  wire logic [31:0] key1,
	output mt_sts_t          sts
);
	localparam int AW = $clog2(STATE_WORDS + 1);
	localparam logic [AW-1:0] LAST = AW'(STATE_WORDS - 1);
	localparam logic [AW-1:0] NW   = AW'(STATE_WORDS);

	typedef enum logic [2:0] {
		P_IDLE, P_INIT, P_MIXA, P_MIXB, P_MIX2A, P_MIX2B, P_TWA, P_TWB
	} ph_t;

	logic [31:0] mem_q [STATE_WORDS];
	logic [31:0] rd_q;
	logic [31:0] prev_q, cur_q, mul_q, t0_q;
	logic [AW-1:0] idx_q, pos_q;
	logic [9:0]  cnt_q;
	logic        j_q, two_q;
	ph_t         ph_q;
	logic [1:0]  sub_q;
	logic        wok_q;
	logic [31:0] word_q;

	logic        we;
	logic [AW-1:0] wa, ra;
	logic [31:0] wd;

	function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
		return (v >= (AW+1)'(STATE_WORDS)) ? AW'(v - (AW+1)'(STATE_WORDS)) : AW'(v);
	endfunction

	always_ff @(posedge clk) begin
		if (we) mem_q[wa[AW-1:0]] <= wd;
		rd_q <= mem_q[ra];
	end

	logic [31:0] px;
	logic [31:0] ysel;
	logic [31:0] twv;
	assign px = prev_q ^ (prev_q >> 30);
	assign ysel = (t0_q & HIGH_BIT) | (rd_q & ~HIGH_BIT);
	assign twv = (ysel >> 1) ^ (ysel[0] ? TWIST_XOR : 32'd0);

	// sub_q steps per element:
	// INIT: 0 mul, 1 write
	// MIX: A: read cur (idx); 0 mul, 1 wait read, 2 write
	// TW: 0 read kk, 1 read nxt, 2 read far, 3 write
	always_comb begin
		we = 1'b0; wa = idx_q; wd = '0; ra = idx_q;
		case (ph_q)
			P_INIT: if (sub_q == 2'd1) begin
				we = 1'b1; wd = mul_q + 32'(idx_q);
			end
			P_MIXA, P_MIX2A: if (sub_q == 2'd2) begin
				we = 1'b1;
				wd = (ph_q == P_MIXA) ? ((cur_q ^ mul_q) + (j_q ? key1 : key0) + 32'(j_q))
				                      : ((cur_q ^ mul_q) - 32'(idx_q));
			end
			P_MIXB, P_MIX2B: begin
				we = 1'b1; wa = '0; wd = prev_q;
			end
			P_TWA: begin
				case (sub_q)
					2'd0: ra = idx_q;
					2'd1: ra = (idx_q == LAST) ? '0 : idx_q + 1'b1;
					2'd2: ra = wrap({1'b0, idx_q} + (AW+1)'(TWIST_OFFSET));
					default: begin
						we = 1'b1; wd = rd_q ^ cur_q;
					end
				endcase
			end
			default: ra = pos_q;
		endcase
		if (ctl.cmd == DP_INIT_START) begin
			we = 1'b1; wa = '0; wd = INIT_SEED;
		end else if (ctl.cmd == DP_FINAL) begin
			we = 1'b1; wa = '0; wd = HIGH_BIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= P_IDLE;
			sub_q <= '0;
			pos_q <= NW;
			wok_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
			j_q   <= 1'b0;
			two_q <= 1'b0;
			prev_q <= '0;
			cur_q  <= '0;
			mul_q  <= '0;
			t0_q   <= '0;
			word_q <= '0;
		end else begin
			wok_q <= 1'b0;
			case (ph_q)
				P_IDLE: begin
					case (ctl.cmd)
						DP_INIT_START: begin
							prev_q <= INIT_SEED; idx_q <= AW'(1); sub_q <= '0; ph_q <= P_INIT;
						end
						DP_MIX_START: begin
							// word 0 still holds the init seed here
							prev_q <= INIT_SEED;
							idx_q <= AW'(1); j_q <= 1'b0; two_q <= ctl.key_two;
							cnt_q <= 10'(STATE_WORDS); sub_q <= '0; ph_q <= P_MIXA;
						end
						DP_FINAL: pos_q <= NW;
						DP_TW_START: begin
							idx_q <= '0; sub_q <= '0; ph_q <= P_TWA;
						end
						DP_DRAW: sub_q <= 2'd1;
						default: ;
					endcase
					if (sub_q == 2'd1 && ctl.cmd != DP_DRAW) begin
						sub_q <= 2'd2;
					end else if (sub_q == 2'd2) begin
						word_q <= temper(rd_q); wok_q <= 1'b1;
						pos_q <= pos_q + 1'b1; sub_q <= '0;
					end
				end
				P_INIT: begin
					if (sub_q == 2'd0) begin
						mul_q <= INIT_MULT * px; sub_q <= 2'd1;
					end else begin
						prev_q <= mul_q + 32'(idx_q);
						sub_q <= '0;
						if (idx_q == LAST) ph_q <= P_IDLE;
						else idx_q <= idx_q + 1'b1;
					end
				end
				P_MIXA, P_MIX2A: begin
					case (sub_q)
						2'd0: begin
							mul_q <= px * ((ph_q == P_MIXA) ? MIX1_MULT : MIX2_MULT);
							sub_q <= 2'd1;
						end
						2'd1: begin
							cur_q <= rd_q; sub_q <= 2'd2;
						end
						default: begin
							prev_q <= wd; sub_q <= '0;
							cnt_q <= cnt_q - 1'b1;
							if (ph_q == P_MIXA) j_q <= two_q ? ~j_q : 1'b0;
							if (idx_q == LAST) begin
								idx_q <= AW'(1);
								ph_q <= (ph_q == P_MIXA) ? P_MIXB : P_MIX2B;
							end else begin
								idx_q <= idx_q + 1'b1;
								if (cnt_q == 10'd1) begin
									if (ph_q == P_MIXA) begin
										ph_q <= P_MIX2A; cnt_q <= 10'(STATE_WORDS - 1);
									end else ph_q <= P_IDLE;
								end
							end
						end
					endcase
				end
				P_MIXB, P_MIX2B: begin
					// wrap: word 0 already written this cycle from prev_q
					if (cnt_q == 10'd0) begin
						if (ph_q == P_MIXB) begin
							ph_q <= P_MIX2A; cnt_q <= 10'(STATE_WORDS - 1);
						end else ph_q <= P_IDLE;
					end else ph_q <= (ph_q == P_MIXB) ? P_MIXA : P_MIX2A;
				end
				P_TWA: begin
					case (sub_q)
						2'd0: sub_q <= 2'd1;
						2'd1: begin
							t0_q <= rd_q; sub_q <= 2'd2;
						end
						2'd2: begin
							cur_q <= twv; sub_q <= 2'd3;
						end
						default: begin
							sub_q <= '0;
							if (idx_q == LAST) begin
								ph_q <= P_IDLE; pos_q <= '0;
							end else idx_q <= idx_q + 1'b1;
						end
					endcase
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	assign sts.busy = (ph_q != P_IDLE);
	assign sts.word_ok = wok_q;
	assign sts.word = word_q;
	assign sts.need_twist = (pos_q >= NW);
endmodule
`default_nettype wire

@@ rtl/core/mt_ctrl.sv @@
// Controller: accepts transactions, sequences datapath commands, forms results.
// Depends on mt_pkg.
`default_nettype none
module mt_ctrl import mt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [63:0] seed,
	input  wire logic [5:0]  bits,
	input  wire logic [30:0] bound,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [52:0]      value,
	output logic             error,
	output mt_ctl_t          ctl,
	output logic [31:0]      key0,
	output logic [31:0]      key1,
	input  wire mt_sts_t     sts
);
	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_INIT_W, S_MIX, S_MIX_W, S_FIN, S_TW_W,
		S_DRAW, S_DRAW_W, S_OUT
	} st_t;

	st_t         st_q;
	op_t         op_q;
	logic [5:0]  k_q;
	logic [30:0] n_q;
	logic [5:0]  len_q;
	logic        seeded_q, second_q, started_q;
	logic [26:0] a_q;
	logic [63:0] mag;
	logic [5:0]  blen;
	logic [31:0] r_bits, r_len;

	assign mag = seed[63] ? (64'd0 - seed) : seed;
	assign in_stall = (st_q != S_IDLE) || out_valid;
	assign r_bits = sts.word >> (6'd32 - k_q);
	assign r_len  = sts.word >> (6'd32 - len_q);

	always_comb begin
		blen = '0;
		for (int i = 0; i < 31; i++) if (bound[i]) blen = 6'(i + 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; seeded_q <= 1'b0; out_valid <= 1'b0;
			ctl <= '{cmd: DP_NOP, key_two: 1'b0};
			started_q <= 1'b0; second_q <= 1'b0;
			op_q <= OP_RESEED; k_q <= '0; n_q <= '0; len_q <= '0; a_q <= '0;
			value <= '0; error <= 1'b0; key0 <= '0; key1 <= '0;
		end else begin
			ctl.cmd <= DP_NOP;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: if (in_valid && !in_stall) begin
					op_q <= op_t'(op); k_q <= bits; n_q <= bound; len_q <= blen;
					value <= '0; error <= 1'b0; second_q <= 1'b0;
					if (op_t'(op) == OP_RESEED) begin
						key0 <= mag[31:0]; key1 <= mag[63:32];
						ctl.key_two <= (mag[63:32] != 32'd0);
						ctl.cmd <= DP_INIT_START; st_q <= S_INIT;
					end else if (!seeded_q || (op_t'(op) == OP_BITS &&
					             (bits == 6'd0 || bits > 6'd32)) ||
					             (op_t'(op) == OP_BOUND && bound == 31'd0)) begin
						error <= 1'b1; out_valid <= 1'b1;
					end else st_q <= S_DRAW;
				end
				S_INIT: st_q <= S_INIT_W;
				S_INIT_W: if (!sts.busy) begin
					ctl.cmd <= DP_MIX_START; st_q <= S_MIX;
				end
				S_MIX: st_q <= S_MIX_W;
				S_MIX_W: if (!sts.busy) begin
					ctl.cmd <= DP_FINAL; st_q <= S_FIN;
				end
				S_FIN: begin
					seeded_q <= 1'b1; out_valid <= 1'b1; st_q <= S_IDLE;
				end
				S_DRAW: if (!sts.busy && !started_q) begin
					started_q <= 1'b1;
					if (sts.need_twist) begin
						ctl.cmd <= DP_TW_START; st_q <= S_TW_W;
					end else begin
						ctl.cmd <= DP_DRAW; st_q <= S_DRAW_W;
					end
				end else started_q <= 1'b0;
				S_TW_W: if (started_q) started_q <= 1'b0;
				else if (!sts.busy) begin
					ctl.cmd <= DP_DRAW; st_q <= S_DRAW_W;
				end
				S_DRAW_W: if (sts.word_ok) begin
					started_q <= 1'b0;
					case (op_q)
						OP_BITS: begin
							value <= 53'(r_bits); st_q <= S_OUT;
						end
						OP_BOUND: begin
							if (r_len < {1'b0, n_q}) begin
								value <= 53'(r_len); st_q <= S_OUT;
							end else st_q <= S_DRAW;
						end
						default: begin
							if (!second_q) begin
								a_q <= sts.word[31:5]; second_q <= 1'b1; st_q <= S_DRAW;
							end else begin
								value <= {a_q, sts.word[31:6]};
								st_q <= S_OUT;
							end
						end
					endcase
				end
				S_OUT: begin
					out_valid <= 1'b1; st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ dv/mt19937_random_generator_chk.sv @@
// Checker for the MT19937 generator: watches both channels, predicts each result
// with its own software twister and compares. Depends on mt_pkg.
`timescale 1ns / 100ps
module mt19937_random_generator_chk import mt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [63:0] seed,
	input  wire logic [5:0]  bits,
	input  wire logic [30:0] bound,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [52:0] value,
	input  wire logic        error,
	output int               fail_count,
	output int               pending,
	output int               results_seen
);
	localparam int NW = 624;
	localparam int OFS = 397;

	logic [31:0] mt [NW];
	int          mt_pos;
	bit          mt_seeded;
	logic [53:0] want_q [$];

	function automatic logic [31:0] mix30(input logic [31:0] p);
		return p ^ (p >> 30);
	endfunction

	function automatic void mt_reseed(input logic [63:0] s);
		logic [63:0] mag;
		logic [31:0] key [2];
		int          klen, i, j, n;
		mag = s[63] ? (64'd0 - s) : s;
		key[0] = mag[31:0];
		key[1] = mag[63:32];
		klen = (key[1] != 0) ? 2 : 1;
		mt[0] = INIT_SEED;
		for (i = 1; i < NW; i++)
			mt[i] = INIT_MULT * mix30(mt[i-1]) + i;
		i = 1;
		j = 0;
		for (n = NW; n > 0; n--) begin
			mt[i] = (mt[i] ^ (mix30(mt[i-1]) * MIX1_MULT)) + key[j] + j;
			i++;
			j++;
			if (i >= NW) begin
				mt[0] = mt[NW-1];
				i = 1;
			end
			if (j >= klen)
				j = 0;
		end
		for (n = NW - 1; n > 0; n--) begin
			mt[i] = (mt[i] ^ (mix30(mt[i-1]) * MIX2_MULT)) - i;
			i++;
			if (i >= NW) begin
				mt[0] = mt[NW-1];
				i = 1;
			end
		end
		mt[0] = HIGH_BIT;
		mt_pos = NW;
	endfunction

	function automatic logic [31:0] mt_next();
		logic [31:0] y;
		if (mt_pos >= NW) begin
			for (int k = 0; k < NW; k++) begin
				y = (mt[k] & HIGH_BIT) | (mt[(k + 1) % NW] & ~HIGH_BIT);
				mt[k] = mt[(k + OFS) % NW] ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
			end
			mt_pos = 0;
		end
		y = mt[mt_pos];
		mt_pos++;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		return y ^ (y >> 18);
	endfunction

	function automatic logic [53:0] mt_predict(input logic [1:0] o, input logic [63:0] s,
			input logic [5:0] k, input logic [30:0] n);
		logic [52:0] v;
		logic [31:0] r;
		int          blen;
		v = '0;
		if (op_t'(o) == OP_RESEED) begin
			mt_reseed(s);
			mt_seeded = 1;
		end else if (!mt_seeded)
			return {53'd0, 1'b1};
		else if (op_t'(o) == OP_BITS) begin
			if (k < 1 || k > 32)
				return {53'd0, 1'b1};
			v = mt_next() >> (32 - k);
		end else if (op_t'(o) == OP_BOUND) begin
			if (n == 0)
				return {53'd0, 1'b1};
			blen = $clog2({1'b0, n} + 32'd1);
			do
				r = mt_next() >> (32 - blen);
			while (r >= n);
			v = r;
		end else begin
			v = {21'd0, mt_next() >> 5} << 26;
			v = v + (mt_next() >> 6);
		end
		return {v, 1'b0};
	endfunction

	assign pending = want_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [53:0] w;
		if (!arst_n) begin
			fail_count <= 0;
			results_seen <= 0;
			mt_pos = NW;
			mt_seeded = 0;
			want_q.delete();
		end else begin
			if (in_valid && !in_stall)
				want_q = {want_q, mt_predict(op, seed, bits, bound)};
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (want_q.size() == 0) begin
					$display("%t: unexpected transaction value=%h error=%b", $time, value, error);
					fail_count <= fail_count + 1;
				end else begin
					w = want_q.pop_front();
					if (w[53:1] !== value || w[0] !== error) begin
						$display("%t: mismatch expected value=%h error=%b, actual value=%h error=%b",
							$time, w[53:1], w[0], value, error);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

@@ dv/mt19937_random_generator_tb.sv @@
// Testbench top for the MT19937 generator: drives random and directed
// transactions with random gaps and stalls. Depends on mt_pkg and the checker.
`timescale 1ns / 100ps
module mt19937_random_generator_tb import mt_pkg::*;;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [1:0]  op;
	logic [63:0] seed;
	logic [5:0]  bits;
	logic [30:0] bound;
	logic [52:0] value;
	logic        error;
	int          fail_count, pending, results_seen;
	int          cycles = 0;
	int          reseeds, draws;
	bit          hold_off;

	mt19937_random_generator dut (.*);
	mt19937_random_generator_chk chk (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	task automatic send(input op_t o, input logic [63:0] s, input logic [5:0] k,
			input logic [30:0] n);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		seed <= s;
		bits <= k;
		bound <= n;
		if (o == OP_RESEED)
			reseeds++;
		else
			draws++;
		do @(posedge clk); while (in_stall);
	endtask

	// stall generator on the result side, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 0;
		else if (hold_off)
			out_stall <= 1;
		else
			out_stall <= (cycles % 400 < 200) ? ($urandom_range(0, 3) == 0) :
				($urandom_range(0, 15) == 0 ? 1'b1 : 1'b0);
	end

	initial begin
		hold_off = 0;
		@(posedge arst_n);
		wait (reseeds > 0 && draws > 200);
		@(posedge clk);
		hold_off <= 1;
		repeat (300) @(posedge clk);
		hold_off <= 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 4000000) begin
			$display("mt19937_random_generator test failed");
			$finish;
		end
	end

	initial begin
		logic [63:0] s;
		op_t o;
		reseeds = 0;
		draws = 0;
		arst_n = 0;
		in_valid = 0;
		op = OP_RESEED;
		seed = '0;
		bits = '0;
		bound = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// refused draws before any reseed
		send(OP_BITS, 64'd0, 6'd32, 31'd1);
		send(OP_BOUND, 64'd0, 6'd0, 31'h7fffffff);
		send(OP_FRAC, '1, 6'd63, 31'd0);
		send(OP_RESEED, 64'h8000000000000000, 6'd0, 31'd0);
		send(OP_BITS, 64'd0, 6'd0, 31'd5);
		send(OP_BITS, 64'd0, 6'd33, 31'd5);
		send(OP_BITS, 64'd0, 6'd63, 31'd5);
		send(OP_BITS, 64'd0, 6'd1, 31'd5);
		send(OP_BITS, 64'd0, 6'd32, 31'd5);
		send(OP_BOUND, 64'd0, 6'd5, 31'd0);
		send(OP_BOUND, 64'd0, 6'd5, 31'd1);
		send(OP_BOUND, 64'd0, 6'd5, 31'h7fffffff);
		send(OP_BOUND, 64'd0, 6'd5, 31'h40000001);
		send(OP_FRAC, 64'd0, 6'd5, 31'd5);
		send(OP_RESEED, 64'd0, 6'd0, 31'd0);
		send(OP_FRAC, 64'd0, 6'd0, 31'd0);
		send(OP_RESEED, 64'h7fffffffffffffff, 6'd0, 31'd0);
		send(OP_BITS, 64'd0, 6'd16, 31'd0);
		send(OP_RESEED, '1, 6'd0, 31'd0);
		send(OP_RESEED, 64'd5489, 6'd0, 31'd0);
		for (int i = 0; i < 1530; i++) begin
			s = {$urandom(), $urandom()};
			if ($urandom_range(0, 1))
				s[63:32] = $urandom_range(0, 1) ? '0 : '1;
			o = op_t'($urandom_range(1, 3));
			if ($urandom_range(0, 150) == 0)
				o = OP_RESEED;
			case ($urandom_range(0, 9))
				0: send(o, s, 6'($urandom()), 31'($urandom()));
				1, 2: send(o, s, 6'($urandom_range(1, 32)), 31'($urandom_range(1, 40)));
				default: send(o, s, 6'($urandom_range(1, 32)), 31'($urandom()) | 31'd1);
			endcase
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d reseeds and %0d draws, %0d results checked",
			reseeds, draws, results_seen);
		if (fail_count == 0)
			$display("mt19937_random_generator test passed");
		else
			$display("mt19937_random_generator test failed");
		$finish;
	end
endmodule
